### hdl/ipac_pkg.sv
// Shared types, codes and constants of the interpolated PID actuator controller.
`default_nettype none
package ipac_pkg;

  localparam logic [31:0] TICK_MIN_DEF = 32'd0;
  localparam logic [31:0] TICK_MAX_DEF = 32'd1048576;

  localparam int DIV_W  = 48;
  localparam int DIVS_W = 16;
  localparam int CNT_W  = $clog2(DIV_W);

  localparam logic [2:0] OP_TICK_UP   = 3'd0;
  localparam logic [2:0] OP_TICK_DOWN = 3'd1;
  localparam logic [2:0] OP_LOAD      = 3'd2;
  localparam logic [2:0] OP_POT       = 3'd3;
  localparam logic [2:0] OP_STEP      = 3'd4;
  localparam logic [2:0] OP_STOP      = 3'd5;

  localparam logic [2:0] REG_P_GAIN     = 3'd0;
  localparam logic [2:0] REG_I_GAIN     = 3'd1;
  localparam logic [2:0] REG_D_GAIN     = 3'd2;
  localparam logic [2:0] REG_TICKS_ROT  = 3'd3;
  localparam logic [2:0] REG_GEAR       = 3'd4;
  localparam logic [2:0] REG_PITCH      = 3'd5;
  localparam logic [2:0] REG_POT_MIN    = 3'd6;
  localparam logic [2:0] REG_POT_MAX    = 3'd7;

  typedef enum logic [2:0] {
    K_INC, K_DEC, K_LOAD, K_POT, K_STEP, K_STOP, K_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] tick_value;
    logic [9:0]  pot_sample;
    logic [11:0] target_length;
    logic [15:0] move_duration;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic signed [15:0] p_gain;
    logic signed [15:0] i_gain;
    logic signed [15:0] d_gain;
    logic [15:0]        counts_per_rev;
    logic [9:0]         gear_reduction;
    logic [7:0]         lead_mm;
    logic [9:0]         pot_at_min;
    logic [9:0]         pot_at_max;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic             rem_nz;
  } div_resp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_POT_GO, S_POT_WAIT, S_LEN1_GO, S_LEN1_WAIT,
    S_LEN2_GO, S_LEN2_WAIT, S_LEN_MUL, S_CTL_LATCH, S_CTL_MUL,
    S_CTL_GO, S_CTL_WAIT, S_CTL_ERR, S_ACC_P, S_ACC_I, S_ACC_D,
    S_DRIVE, S_OUT
  } state_e;

endpackage
`default_nettype wire

### hdl/ipac_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ipac_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ipac_pkg::div_req_t  req_i,
  output ipac_pkg::div_resp_t      resp_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [ipac_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [ipac_pkg::DIV_W-1:0]        quo_q, quo_d;
  logic [ipac_pkg::DIVS_W-1:0]       rem_q, rem_d;
  logic [ipac_pkg::DIVS_W-1:0]       dvs_q, dvs_d;
  logic [ipac_pkg::DIVS_W:0]         trial;
  logic                              ge;

  assign trial = {rem_q, quo_q[ipac_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ipac_pkg::CNT_W'(ipac_pkg::DIV_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? ipac_pkg::DIVS_W'(trial - {1'b0, dvs_q}) : trial[ipac_pkg::DIVS_W-1:0];
      quo_d = {quo_q[ipac_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign resp_o.done     = done_q;
  assign resp_o.quotient = quo_q;
  assign resp_o.rem_nz   = rem_q != '0;

endmodule
`default_nettype wire

### hdl/ipac_front.sv
// Input side: accept words, decode the operation and queue them for the back end.
`default_nettype none
module ipac_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [2:0]    operation_i,
  input  wire logic [31:0]   tick_value_i,
  input  wire logic [9:0]    pot_sample_i,
  input  wire logic [11:0]   target_length_i,
  input  wire logic [15:0]   move_duration_i,
  input  wire logic [31:0]   now_ms_i,
  output logic               q_valid_o,
  output ipac_pkg::item_t    q_item_o,
  input  wire logic          q_pop_i
);

  ipac_pkg::item_t  mem_q [2];
  ipac_pkg::item_t  item;
  ipac_pkg::kind_e  kind;
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             push;

  always_comb begin
    unique case (operation_i)
      ipac_pkg::OP_TICK_UP:   kind = ipac_pkg::K_INC;
      ipac_pkg::OP_TICK_DOWN: kind = ipac_pkg::K_DEC;
      ipac_pkg::OP_LOAD:      kind = ipac_pkg::K_LOAD;
      ipac_pkg::OP_POT:       kind = ipac_pkg::K_POT;
      ipac_pkg::OP_STEP:      kind = ipac_pkg::K_STEP;
      ipac_pkg::OP_STOP:      kind = ipac_pkg::K_STOP;
      default:                kind = ipac_pkg::K_NOP;
    endcase
  end

  assign item.kind          = kind;
  assign item.tick_value    = tick_value_i;
  assign item.pot_sample    = pot_sample_i;
  assign item.target_length = target_length_i;
  assign item.move_duration = move_duration_i;
  assign item.now_ms        = now_ms_i;

  assign in_ready_o = cnt_q != 2'd2;
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? !wp_q : wp_q;
    rp_d  = q_pop_i ? !rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item;
    end
  end

endmodule
`default_nettype wire

### hdl/ipac_back.sv
// Back end: tick update, length calculation, interpolated PID step and result register.
`default_nettype none
module ipac_back #(
  parameter logic [31:0] TICK_MIN = ipac_pkg::TICK_MIN_DEF,
  parameter logic [31:0] TICK_MAX = ipac_pkg::TICK_MAX_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ipac_pkg::cfg_t       cfg_i,
  input  wire logic                 q_valid_i,
  input  wire ipac_pkg::item_t      q_item_i,
  output logic                      q_pop_o,
  output ipac_pkg::div_req_t        div_req_o,
  input  wire ipac_pkg::div_resp_t  div_resp_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                pwm_duty_o,
  output logic                      drive_extend_o,
  output logic signed [12:0]        length_error_o,
  output logic [31:0]               tick_count_o,
  output logic [11:0]               rod_length_o
);

  localparam logic signed [33:0] SpanOut =
    $signed({2'b00, TICK_MAX}) - $signed({2'b00, TICK_MIN});

  ipac_pkg::state_e state_q, state_d;
  ipac_pkg::item_t  item_q;

  logic [31:0]        ticks_q, q1_q, q2_q, start_time_q;
  logic [11:0]        len_q, last_target_q, start_length_q, goal_q;
  logic signed [12:0] hist_q [3];
  logic signed [12:0] err_q, lerr_q;
  logic [7:0]         duty_q;
  logic               dir_q, dbl_q, neg_q;
  logic signed [44:0] prod_q;
  logic signed [33:0] acc_q;

  logic signed [10:0] pot_diff, span_in;
  logic [15:0]        t_eff;
  logic [9:0]         g_eff;
  logic [39:0]        len_prod;
  logic [31:0]        elapsed, q_lo;
  logic signed [12:0] diff, err_n;
  logic signed [14:0] hsum;
  logic signed [28:0] mul_p, mul_d;
  logic signed [30:0] mul_i;
  logic signed [33:0] acc_abs;
  logic [47:0]        q_adj;
  logic out_free;

  assign pot_diff = $signed({1'b0, item_q.pot_sample}) - $signed({1'b0, cfg_i.pot_at_min});
  assign span_in  = $signed({1'b0, cfg_i.pot_at_max}) - $signed({1'b0, cfg_i.pot_at_min});
  assign t_eff    = (cfg_i.counts_per_rev == '0) ? 16'd1 : cfg_i.counts_per_rev;
  assign g_eff    = (cfg_i.gear_reduction == '0) ? 10'd1 : cfg_i.gear_reduction;
  assign len_prod = q2_q * cfg_i.lead_mm;
  assign elapsed  = item_q.now_ms - start_time_q;
  assign diff     = $signed({1'b0, item_q.target_length}) - $signed({1'b0, start_length_q});
  assign err_n    = $signed({1'b0, goal_q}) - $signed({1'b0, len_q});
  assign hsum     = 15'(hist_q[0]) + 15'(hist_q[1]) + 15'(hist_q[2]);
  assign mul_p    = cfg_i.p_gain * err_q;
  assign mul_i    = cfg_i.i_gain * hsum;
  assign mul_d    = cfg_i.d_gain * err_q;
  assign acc_abs  = acc_q[33] ? -acc_q : acc_q;
  // floor toward minus infinity for the interpolation quotient
  assign q_adj    = div_resp_i.quotient + {47'd0, neg_q & div_resp_i.rem_nz};
  assign q_lo     = neg_q ? -div_resp_i.quotient[31:0] : div_resp_i.quotient[31:0];
  assign out_free = !out_valid_o || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipac_pkg::S_IDLE:      if (q_valid_i) state_d = ipac_pkg::S_EXEC;
      ipac_pkg::S_EXEC: begin
        if (item_q.kind == ipac_pkg::K_POT && span_in != '0) state_d = ipac_pkg::S_POT_GO;
        else state_d = ipac_pkg::S_LEN1_GO;
      end
      ipac_pkg::S_POT_GO:    state_d = ipac_pkg::S_POT_WAIT;
      ipac_pkg::S_POT_WAIT:  if (div_resp_i.done) state_d = ipac_pkg::S_LEN1_GO;
      ipac_pkg::S_LEN1_GO:   state_d = ipac_pkg::S_LEN1_WAIT;
      ipac_pkg::S_LEN1_WAIT: if (div_resp_i.done) state_d = ipac_pkg::S_LEN2_GO;
      ipac_pkg::S_LEN2_GO:   state_d = ipac_pkg::S_LEN2_WAIT;
      ipac_pkg::S_LEN2_WAIT: if (div_resp_i.done) state_d = ipac_pkg::S_LEN_MUL;
      ipac_pkg::S_LEN_MUL: begin
        state_d = (item_q.kind == ipac_pkg::K_STEP) ? ipac_pkg::S_CTL_LATCH : ipac_pkg::S_OUT;
      end
      ipac_pkg::S_CTL_LATCH: state_d = ipac_pkg::S_CTL_MUL;
      ipac_pkg::S_CTL_MUL: begin
        state_d = (elapsed < {16'd0, item_q.move_duration}) ? ipac_pkg::S_CTL_GO
                                                            : ipac_pkg::S_CTL_ERR;
      end
      ipac_pkg::S_CTL_GO:    state_d = ipac_pkg::S_CTL_WAIT;
      ipac_pkg::S_CTL_WAIT:  if (div_resp_i.done) state_d = ipac_pkg::S_CTL_ERR;
      ipac_pkg::S_CTL_ERR:   state_d = ipac_pkg::S_ACC_P;
      ipac_pkg::S_ACC_P:     state_d = ipac_pkg::S_ACC_I;
      ipac_pkg::S_ACC_I:     state_d = ipac_pkg::S_ACC_D;
      ipac_pkg::S_ACC_D:     state_d = ipac_pkg::S_DRIVE;
      ipac_pkg::S_DRIVE:     state_d = ipac_pkg::S_OUT;
      ipac_pkg::S_OUT:       if (out_free) state_d = ipac_pkg::S_IDLE;
      default:               state_d = ipac_pkg::S_IDLE;
    endcase
  end

  // outputs toward queue and divider
  always_comb begin
    q_pop_o            = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = 16'd1;
    unique case (state_q)
      ipac_pkg::S_IDLE: q_pop_o = q_valid_i;
      ipac_pkg::S_POT_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = 48'(prod_q[44] ? -prod_q : prod_q);
        div_req_o.divisor  = 16'(span_in[10] ? -span_in : span_in);
      end
      ipac_pkg::S_LEN1_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = {16'd0, ticks_q};
        div_req_o.divisor  = t_eff;
      end
      ipac_pkg::S_LEN2_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = {16'd0, q1_q};
        div_req_o.divisor  = {6'd0, g_eff};
      end
      ipac_pkg::S_CTL_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = 48'(prod_q[44] ? -prod_q : prod_q);
        div_req_o.divisor  = item_q.move_duration;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ipac_pkg::S_IDLE;
      ticks_q        <= '0;
      hist_q[0]      <= '0;
      hist_q[1]      <= '0;
      hist_q[2]      <= '0;
      last_target_q  <= '0;
      start_length_q <= '0;
      start_time_q   <= '0;
      duty_q         <= '0;
      dir_q          <= 1'b1;
      out_valid_o    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ipac_pkg::S_OUT && out_free) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        ipac_pkg::S_EXEC: begin
          case (item_q.kind)
            ipac_pkg::K_INC:  ticks_q <= ticks_q + 32'd1;
            ipac_pkg::K_DEC:  ticks_q <= ticks_q - 32'd1;
            ipac_pkg::K_LOAD: ticks_q <= item_q.tick_value;
            ipac_pkg::K_POT:  if (span_in == '0) ticks_q <= TICK_MIN;
            ipac_pkg::K_STOP: duty_q <= '0;
            default: ;
          endcase
        end
        ipac_pkg::S_POT_WAIT: if (div_resp_i.done) ticks_q <= q_lo + TICK_MIN;
        ipac_pkg::S_CTL_LATCH: begin
          if (item_q.target_length != last_target_q) begin
            last_target_q  <= item_q.target_length;
            start_length_q <= len_q;
            start_time_q   <= item_q.now_ms;
          end
        end
        ipac_pkg::S_CTL_ERR: begin
          hist_q[2] <= hist_q[1];
          hist_q[1] <= hist_q[0];
          hist_q[0] <= err_n;
        end
        ipac_pkg::S_DRIVE: begin
          dir_q  <= !acc_q[33];
          duty_q <= (acc_abs[33:8] > 26'd255) ? 8'd255 : acc_abs[15:8];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ipac_pkg::S_IDLE: if (q_valid_i) item_q <= q_item_i;
      ipac_pkg::S_EXEC: begin
        lerr_q <= '0;
        prod_q <= 45'(pot_diff * SpanOut);
        neg_q  <= (pot_diff[10] ^ span_in[10] ^ SpanOut[33]) && pot_diff != '0;
      end
      ipac_pkg::S_LEN1_WAIT: if (div_resp_i.done) q1_q <= div_resp_i.quotient[31:0];
      ipac_pkg::S_LEN2_WAIT: if (div_resp_i.done) q2_q <= div_resp_i.quotient[31:0];
      ipac_pkg::S_LEN_MUL:   len_q <= (len_prod > 40'd4095) ? 12'd4095 : len_prod[11:0];
      ipac_pkg::S_CTL_MUL: begin
        prod_q <= 45'(diff * $signed({1'b0, elapsed[15:0]}));
        neg_q  <= diff[12];
        goal_q <= item_q.target_length;
        dbl_q  <= 1'b1;
      end
      ipac_pkg::S_CTL_WAIT: begin
        if (div_resp_i.done) begin
          goal_q <= neg_q ? start_length_q - q_adj[11:0] : start_length_q + q_adj[11:0];
          dbl_q  <= 1'b0;
        end
      end
      ipac_pkg::S_CTL_ERR: begin
        err_q  <= err_n;
        lerr_q <= $signed({1'b0, item_q.target_length}) - $signed({1'b0, len_q});
        acc_q  <= '0;
      end
      ipac_pkg::S_ACC_P: acc_q <= acc_q + (dbl_q ? 34'(mul_p) <<< 1 : 34'(mul_p));
      ipac_pkg::S_ACC_I: acc_q <= acc_q + (dbl_q ? 34'(mul_i) <<< 1 : 34'(mul_i));
      ipac_pkg::S_ACC_D: acc_q <= acc_q + 34'(mul_d);
      ipac_pkg::S_OUT: begin
        if (out_free) begin
          pwm_duty_o     <= duty_q;
          drive_extend_o <= dir_q;
          length_error_o <= lerr_q;
          tick_count_o   <= ticks_q;
          rod_length_o   <= len_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### hdl/interpolated_pid_actuator_control.sv
// Divider: the shared 48-step divider runs two to three times per word, three for a pot
// load with a nonzero pot span or for a control step that still interpolates.
// Throughput: one word at a time in the back end; a two-word queue and the result
// register let input and output stall on their own.
// Reset: asynchronous, active low; ticks, error history, target latch and held drive
// clear, direction reads extend, configuration returns to its reset values.
`default_nettype none
module interpolated_pid_actuator_control #(
  parameter logic [31:0] TICK_MIN = ipac_pkg::TICK_MIN_DEF,
  parameter logic [31:0] TICK_MAX = ipac_pkg::TICK_MAX_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [2:0]   operation_i,
  input  wire logic [31:0]  tick_value_i,
  input  wire logic [9:0]   pot_sample_i,
  input  wire logic [11:0]  target_length_i,
  input  wire logic [15:0]  move_duration_i,
  input  wire logic [31:0]  now_ms_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [7:0]        pwm_duty_o,
  output logic              drive_extend_o,
  output logic signed [12:0] length_error_o,
  output logic [31:0]       tick_count_o,
  output logic [11:0]       rod_length_o
);

  ipac_pkg::cfg_t      cfg_q;
  ipac_pkg::item_t     q_item;
  ipac_pkg::div_req_t  div_req;
  ipac_pkg::div_resp_t div_resp;
  logic                q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.p_gain         <= 16'sd256;
      cfg_q.i_gain         <= '0;
      cfg_q.d_gain         <= '0;
      cfg_q.counts_per_rev <= 16'd1;
      cfg_q.gear_reduction <= 10'd1;
      cfg_q.lead_mm        <= 8'd1;
      cfg_q.pot_at_min     <= '0;
      cfg_q.pot_at_max     <= 10'd1023;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipac_pkg::REG_P_GAIN:    cfg_q.p_gain         <= cfg_data_i;
        ipac_pkg::REG_I_GAIN:    cfg_q.i_gain         <= cfg_data_i;
        ipac_pkg::REG_D_GAIN:    cfg_q.d_gain         <= cfg_data_i;
        ipac_pkg::REG_TICKS_ROT: cfg_q.counts_per_rev <= cfg_data_i;
        ipac_pkg::REG_GEAR:      cfg_q.gear_reduction <= cfg_data_i[9:0];
        ipac_pkg::REG_PITCH:     cfg_q.lead_mm        <= cfg_data_i[7:0];
        ipac_pkg::REG_POT_MIN:   cfg_q.pot_at_min     <= cfg_data_i[9:0];
        ipac_pkg::REG_POT_MAX:   cfg_q.pot_at_max     <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  ipac_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .tick_value_i    (tick_value_i),
    .pot_sample_i    (pot_sample_i),
    .target_length_i (target_length_i),
    .move_duration_i (move_duration_i),
    .now_ms_i        (now_ms_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  ipac_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .resp_o (div_resp)
  );

  ipac_back #(
    .TICK_MIN (TICK_MIN),
    .TICK_MAX (TICK_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .div_req_o      (div_req),
    .div_resp_i     (div_resp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pwm_duty_o     (pwm_duty_o),
    .drive_extend_o (drive_extend_o),
    .length_error_o (length_error_o),
    .tick_count_o   (tick_count_o),
    .rod_length_o   (rod_length_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_start_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_req.start) else $error("divider started twice in a row");
  a_done_not_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_resp.done |-> !div_req.start) else $error("divider restarted on completion");
  a_full_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid) else $error("input stalled with empty queue");
`endif

endmodule
`default_nettype wire

### test/ipac_checker.sv
// Checker for the actuator controller: mirrors config writes, predicts each status word, compares.
`timescale 1ns / 1ps
module ipac_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  input  wire logic         in_ready_i,
  input  wire logic [2:0]   operation_i,
  input  wire logic [31:0]  tick_value_i,
  input  wire logic [9:0]   pot_sample_i,
  input  wire logic [11:0]  target_length_i,
  input  wire logic [15:0]  move_duration_i,
  input  wire logic [31:0]  now_ms_i,
  input  wire logic         out_valid_i,
  input  wire logic         out_ready_i,
  input  wire logic [7:0]   pwm_duty_i,
  input  wire logic         drive_extend_i,
  input  wire logic [12:0]  length_error_i,
  input  wire logic [31:0]  tick_count_i,
  input  wire logic [11:0]  rod_length_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);

  typedef struct {
    logic [7:0]  duty;
    logic        extend;
    logic [12:0] len_err;
    logic [31:0] ticks;
    logic [11:0] rod_len;
  } status_t;

  ipac_pkg::cfg_t cfg;
  logic [31:0] ticks_q;
  int          err_hist[3];
  logic [11:0] last_target;
  logic [11:0] start_len;
  logic [31:0] start_ms;
  logic [7:0]  duty_q;
  logic        extend_q;
  status_t     status_q[$];

  function automatic logic [11:0] rod_length_of(logic [31:0] t);
    longint unsigned tpr, gear, v;
    tpr  = (cfg.counts_per_rev == 0) ? 1 : cfg.counts_per_rev;
    gear = (cfg.gear_reduction == 0) ? 1 : cfg.gear_reduction;
    v = ({32'b0, t} / tpr / gear) * cfg.lead_mm;
    return (v > 4095) ? 12'd4095 : v[11:0];
  endfunction

  // Advance the controller state by one word and return the status it reports.
  task automatic run_word(input logic [2:0] op, input logic [31:0] tval,
                          input logic [9:0] pot, input logic [11:0] tgt,
                          input logic [15:0] dur, input logic [31:0] now,
                          output status_t s);
    longint lerr, len, goal, err, sum, acc, mag, m, num, q, span_in, v;
    logic [31:0] elapsed;
    lerr = 0;
    case (op)
      ipac_pkg::OP_TICK_UP:   ticks_q = ticks_q + 32'd1;
      ipac_pkg::OP_TICK_DOWN: ticks_q = ticks_q - 32'd1;
      ipac_pkg::OP_LOAD:      ticks_q = tval;
      ipac_pkg::OP_POT: begin
        span_in = longint'(cfg.pot_at_max) - longint'(cfg.pot_at_min);
        if (span_in == 0) begin
          v = longint'(ipac_pkg::TICK_MIN_DEF);
        end else begin
          v = (longint'(pot) - longint'(cfg.pot_at_min))
              * (longint'(ipac_pkg::TICK_MAX_DEF) - longint'(ipac_pkg::TICK_MIN_DEF))
              / span_in + longint'(ipac_pkg::TICK_MIN_DEF);
        end
        ticks_q = v[31:0];
      end
      ipac_pkg::OP_STEP: begin
        len = longint'(rod_length_of(ticks_q));
        if (tgt != last_target) begin
          last_target = tgt;
          start_len   = len[11:0];
          start_ms    = now;
        end
        elapsed = now - start_ms;
        if (elapsed < dur) begin
          num = (longint'(tgt) - longint'(start_len)) * longint'(elapsed);
          q = num / longint'(dur);
          // round toward minus infinity
          if ((num % longint'(dur)) != 0 && num < 0) q = q - 1;
          goal = longint'(start_len) + q;
          m = 1;
        end else begin
          goal = longint'(tgt);
          m = 2;
        end
        err = goal - len;
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = int'(err);
        sum = longint'(err_hist[0]) + err_hist[1] + err_hist[2];
        acc = m * longint'(cfg.p_gain) * err + m * longint'(cfg.i_gain) * sum
              + longint'(cfg.d_gain) * err;
        extend_q = (acc >= 0);
        mag = ((acc < 0) ? -acc : acc) / 256;
        duty_q = (mag > 255) ? 8'd255 : mag[7:0];
        lerr = longint'(tgt) - len;
      end
      ipac_pkg::OP_STOP: duty_q = 8'd0;
      default: ;
    endcase
    s.duty    = duty_q;
    s.extend  = extend_q;
    s.len_err = lerr[12:0];
    s.ticks   = ticks_q;
    s.rod_len = rod_length_of(ticks_q);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    status_t exp_s, next_s;
    if (!rst_ni) begin
      cfg.p_gain         = 16'sd256;
      cfg.i_gain         = 16'sd0;
      cfg.d_gain         = 16'sd0;
      cfg.counts_per_rev = 16'd1;
      cfg.gear_reduction = 10'd1;
      cfg.lead_mm        = 8'd1;
      cfg.pot_at_min     = 10'd0;
      cfg.pot_at_max     = 10'd1023;
      ticks_q     = '0;
      err_hist    = '{0, 0, 0};
      last_target = '0;
      start_len   = '0;
      start_ms    = '0;
      duty_q      = '0;
      extend_q    = 1'b1;
      fail_count_o = 0;
      checked_o    = 0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ipac_pkg::REG_P_GAIN:    cfg.p_gain         = cfg_data_i;
          ipac_pkg::REG_I_GAIN:    cfg.i_gain         = cfg_data_i;
          ipac_pkg::REG_D_GAIN:    cfg.d_gain         = cfg_data_i;
          ipac_pkg::REG_TICKS_ROT: cfg.counts_per_rev = cfg_data_i;
          ipac_pkg::REG_GEAR:      cfg.gear_reduction = cfg_data_i[9:0];
          ipac_pkg::REG_PITCH:     cfg.lead_mm        = cfg_data_i[7:0];
          ipac_pkg::REG_POT_MIN:   cfg.pot_at_min     = cfg_data_i[9:0];
          ipac_pkg::REG_POT_MAX:   cfg.pot_at_max     = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (status_q.size() == 0) begin
          $error("status word with no prediction waiting");
          fail_count_o++;
        end else begin
          exp_s = status_q.pop_front();
          check_field("pwm_duty", 32'(exp_s.duty), 32'(pwm_duty_i));
          check_field("drive_extend", 32'(exp_s.extend), 32'(drive_extend_i));
          check_field("length_error", 32'(exp_s.len_err), 32'(length_error_i));
          check_field("tick_count", exp_s.ticks, tick_count_i);
          check_field("rod_length", 32'(exp_s.rod_len), 32'(rod_length_i));
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        run_word(operation_i, tick_value_i, pot_sample_i, target_length_i,
                 move_duration_i, now_ms_i, next_s);
        status_q.push_back(next_s);
      end
    end
    pending_o = status_q.size();
  end

endmodule

### test/tb_top.sv
// Top of the actuator controller testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int PHASES        = 6;
  localparam int WORDS_PER_SET = 310;
  localparam int HOLD_CYCLES   = 3000;
  localparam int CYCLE_LIMIT   = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  operation = '0;
  logic [31:0] tick_value = '0;
  logic [9:0]  pot_sample = '0;
  logic [11:0] target_length = '0;
  logic [15:0] move_duration = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pwm_duty;
  logic        drive_extend;
  logic signed [12:0] length_error;
  logic [31:0] tick_count;
  logic [11:0] rod_length;

  int fail_count, pending, checked;
  logic in_fire_q = 1'b0;
  logic hold_req = 1'b0;
  int burst_left = 0;
  int sent = 0;
  int cycles = 0;
  logic [31:0] ms_clock = '0;
  logic [11:0] cur_target = '0;

  interpolated_pid_actuator_control dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(operation), .tick_value_i(tick_value), .pot_sample_i(pot_sample),
    .target_length_i(target_length), .move_duration_i(move_duration), .now_ms_i(now_ms),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .pwm_duty_o(pwm_duty), .drive_extend_o(drive_extend), .length_error_o(length_error),
    .tick_count_o(tick_count), .rod_length_o(rod_length)
  );

  ipac_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(operation), .tick_value_i(tick_value), .pot_sample_i(pot_sample),
    .target_length_i(target_length), .move_duration_i(move_duration), .now_ms_i(now_ms),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .pwm_duty_i(pwm_duty), .drive_extend_i(drive_extend), .length_error_i(length_error),
    .tick_count_i(tick_count), .rod_length_i(rod_length),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_fire_q <= in_valid && in_ready;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: hold off once when asked, else stall on a changing pattern.
  initial begin
    int mode, mode_left, hold_left;
    logic rdy, hold_used;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 5) == 0);
          default: rdy = ($urandom_range(0, 5) != 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  // Offer one word and hold it until taken; called at a falling edge.
  task automatic send_word(input logic [2:0] op, input logic [31:0] tval,
                           input logic [9:0] pot, input logic [11:0] tgt,
                           input logic [15:0] dur, input logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    operation     <= op;
    tick_value    <= tval;
    pot_sample    <= pot;
    target_length <= tgt;
    move_duration <= dur;
    now_ms        <= now;
    in_valid      <= 1'b1;
    do @(negedge clk_i); while (!in_fire_q);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= 3'(i);
      cfg_data <= vals[i];
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_word();
    int pick;
    logic [2:0] op;
    logic [31:0] tval;
    logic [15:0] dur;
    pick = $urandom_range(0, 99);
    if (pick < 38) op = ipac_pkg::OP_STEP;
    else if (pick < 58) op = ipac_pkg::OP_TICK_UP;
    else if (pick < 72) op = ipac_pkg::OP_TICK_DOWN;
    else if (pick < 81) op = ipac_pkg::OP_LOAD;
    else if (pick < 90) op = ipac_pkg::OP_POT;
    else if (pick < 96) op = ipac_pkg::OP_STOP;
    else op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    pick = $urandom_range(0, 9);
    if (pick < 3) tval = $urandom_range(0, 5000);
    else if (pick < 8) tval = $urandom_range(0, 32'h0010_0000);
    else tval = $urandom;
    if ($urandom_range(0, 9) < 3) begin
      pick = $urandom_range(0, 9);
      cur_target = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 : 12'($urandom);
    end
    if ($urandom_range(0, 19) == 0) ms_clock = $urandom;
    else ms_clock = ms_clock + $urandom_range(0, 50);
    pick = $urandom_range(0, 9);
    if (pick == 0) dur = '0;
    else if (pick < 7) dur = 16'($urandom_range(1, 300));
    else dur = 16'($urandom_range(0, 65535));
    send_word(op, tval, 10'($urandom), cur_target, dur, ms_clock);
  endtask

  initial begin
    logic [15:0] vals[8];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    vals[ipac_pkg::REG_P_GAIN]    = 16'd256;
    vals[ipac_pkg::REG_I_GAIN]    = 16'd0;
    vals[ipac_pkg::REG_D_GAIN]    = 16'd0;
    vals[ipac_pkg::REG_TICKS_ROT] = 16'd1;
    vals[ipac_pkg::REG_GEAR]      = 16'd1;
    vals[ipac_pkg::REG_PITCH]     = 16'd1;
    vals[ipac_pkg::REG_POT_MIN]   = 16'd0;
    vals[ipac_pkg::REG_POT_MAX]   = 16'd1023;
    write_cfg(vals);

    // Directed: wrap both ways, loads, pot ends, new target, interpolation, stop.
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd0, 16'd0, 32'd0);
    send_word(ipac_pkg::OP_TICK_DOWN, '0, '0, '0, '0, '0);
    send_word(ipac_pkg::OP_TICK_UP, '0, '0, '0, '0, '0);
    send_word(ipac_pkg::OP_LOAD, 32'hFFFF_FFFF, 10'h3FF, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(ipac_pkg::OP_TICK_UP, '0, '0, '0, '0, '0);
    send_word(ipac_pkg::OP_POT, '0, 10'd0, '0, '0, '0);
    send_word(ipac_pkg::OP_POT, '0, 10'd1023, '0, '0, '0);
    send_word(ipac_pkg::OP_POT, '0, 10'd3, '0, '0, '0);
    send_word(ipac_pkg::OP_LOAD, 32'd50, '0, '0, '0, '0);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd4095, 16'd0, 32'd10);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd100, 16'd1000, 32'd20);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd100, 16'd1000, 32'd520);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd100, 16'd1000, 32'd2000);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd10, 16'd65535, 32'hFFFF_FFF0);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd10, 16'd65535, 32'd100);
    send_word(ipac_pkg::OP_STOP, '0, '0, '0, '0, '0);
    send_word(OP_SPARE_A, '0, '0, '0, '0, '0);
    send_word(OP_SPARE_B, '0, '0, '0, '0, '0);
    send_word(ipac_pkg::OP_LOAD, 32'h0000_0000, '0, '0, '0, '0);
    send_word(ipac_pkg::OP_STEP, '0, '0, 12'd4095, 16'd1, 32'd5000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          vals[ipac_pkg::REG_P_GAIN]    = 16'd256;
          vals[ipac_pkg::REG_I_GAIN]    = 16'd64;
          vals[ipac_pkg::REG_D_GAIN]    = 16'd32;
          vals[ipac_pkg::REG_TICKS_ROT] = 16'd4;
          vals[ipac_pkg::REG_GEAR]      = 16'd2;
          vals[ipac_pkg::REG_PITCH]     = 16'd3;
          vals[ipac_pkg::REG_POT_MIN]   = 16'd100;
          vals[ipac_pkg::REG_POT_MAX]   = 16'd900;
        end
        1: begin
          vals[ipac_pkg::REG_P_GAIN]    = 16'h7FFF;
          vals[ipac_pkg::REG_I_GAIN]    = 16'h7FFF;
          vals[ipac_pkg::REG_D_GAIN]    = 16'h7FFF;
          vals[ipac_pkg::REG_TICKS_ROT] = 16'hFFFF;
          vals[ipac_pkg::REG_GEAR]      = 16'd1023;
          vals[ipac_pkg::REG_PITCH]     = 16'd255;
          vals[ipac_pkg::REG_POT_MIN]   = 16'd1023;
          vals[ipac_pkg::REG_POT_MAX]   = 16'd0;
        end
        2: begin
          vals[ipac_pkg::REG_P_GAIN]    = 16'h8000;
          vals[ipac_pkg::REG_I_GAIN]    = 16'h8000;
          vals[ipac_pkg::REG_D_GAIN]    = 16'h8000;
          vals[ipac_pkg::REG_TICKS_ROT] = 16'd0;
          vals[ipac_pkg::REG_GEAR]      = 16'd0;
          vals[ipac_pkg::REG_PITCH]     = 16'd1;
          vals[ipac_pkg::REG_POT_MIN]   = 16'd512;
          vals[ipac_pkg::REG_POT_MAX]   = 16'd512;
        end
        default: begin
          vals[ipac_pkg::REG_P_GAIN]    = 16'($urandom);
          vals[ipac_pkg::REG_I_GAIN]    = 16'($urandom);
          vals[ipac_pkg::REG_D_GAIN]    = 16'($urandom);
          vals[ipac_pkg::REG_TICKS_ROT] = 16'($urandom_range(0, 64));
          vals[ipac_pkg::REG_GEAR]      = 16'($urandom_range(0, 8));
          vals[ipac_pkg::REG_PITCH]     = 16'($urandom_range(1, 255));
          vals[ipac_pkg::REG_POT_MIN]   = 16'($urandom_range(0, 1023));
          vals[ipac_pkg::REG_POT_MAX]   = 16'($urandom_range(0, 1023));
        end
      endcase
      write_cfg(vals);
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        // one long receiver hold-off to back up the input side
        if (ph == 3 && n == 50) hold_req = 1'b1;
        random_word();
      end
      drain();
    end

    $display("Sent %0d words across %0d register settings, %0d status words checked",
             sent, PHASES + 1, checked);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ipac_pkg.sv
hdl/ipac_div.sv
hdl/ipac_front.sv
hdl/ipac_back.sv
hdl/interpolated_pid_actuator_control.sv
test/ipac_checker.sv
test/tb_top.sv
